### hdl/spfl_pkg.sv
// ----------------------------------------------------------------------------
// spfl_pkg
// Shared types and command codes for the serial pixel frame loader.
// ----------------------------------------------------------------------------
package spfl_pkg;

    localparam logic [7:0] CMD_START    = 8'h01;
    localparam logic [7:0] CMD_DUMP     = 8'h02;
    localparam logic [7:0] CMD_POSITION = 8'h03;
    localparam logic [7:0] CMD_RED      = 8'h04;
    localparam logic [7:0] CMD_GREEN    = 8'h05;
    localparam logic [7:0] CMD_BLUE     = 8'h06;
    localparam logic [7:0] BYTE_BIAS    = 8'h01;

    typedef enum logic [2:0] {
        OP_DUMP     = 3'd0,
        OP_POSITION = 3'd1,
        OP_RED      = 3'd2,
        OP_GREEN    = 3'd3,
        OP_BLUE     = 3'd4
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] value;
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } back_state_t;

endpackage

### hdl/spfl_front.sv
// ----------------------------------------------------------------------------
// spfl_front
// Pairs incoming bytes as command then value and decodes them into operations.
// ----------------------------------------------------------------------------
module spfl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      rx_byte,
    output logic            push,
    output spfl_pkg::op_t   push_op,
    input  logic            full
);

    logic       awaiting_reg, awaiting_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] cmd;
    logic       known;
    logic       beat;

    assign in_ready = !awaiting_reg || !full;
    assign beat     = in_valid && in_ready;
    assign cmd      = held_reg - spfl_pkg::BYTE_BIAS;

    always_comb
    begin
        known        = 1'b1;
        push_op.kind = spfl_pkg::OP_DUMP;
        push_op.value = rx_byte - spfl_pkg::BYTE_BIAS;
        case (cmd)
            spfl_pkg::CMD_DUMP:     push_op.kind = spfl_pkg::OP_DUMP;
            spfl_pkg::CMD_POSITION: push_op.kind = spfl_pkg::OP_POSITION;
            spfl_pkg::CMD_RED:      push_op.kind = spfl_pkg::OP_RED;
            spfl_pkg::CMD_GREEN:    push_op.kind = spfl_pkg::OP_GREEN;
            spfl_pkg::CMD_BLUE:     push_op.kind = spfl_pkg::OP_BLUE;
            spfl_pkg::CMD_START:    known = 1'b0;
            default:                known = 1'b0;
        endcase
    end

    assign push = beat && awaiting_reg && known;

    always_comb
    begin
        awaiting_next = awaiting_reg;
        held_next     = held_reg;
        if (beat)
        begin
            awaiting_next = !awaiting_reg;
            if (!awaiting_reg)
            begin
                held_next = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            held_reg     <= 8'h00;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            held_reg     <= held_next;
        end
    end

endmodule

### hdl/spfl_queue.sv
// ----------------------------------------------------------------------------
// spfl_queue
// Two-entry operation queue between the decoder and the executor.
// ----------------------------------------------------------------------------
module spfl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spfl_pkg::op_t   push_op,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output spfl_pkg::op_t   head_op
);

    spfl_pkg::op_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_op   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/spfl_back.sv
// ----------------------------------------------------------------------------
// spfl_back
// Executes operations: cursor, colour stores and the frame dump sequencer.
// ----------------------------------------------------------------------------
module spfl_back #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            not_empty,
    input  spfl_pkg::op_t   head_op,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [5:0]      pixel_index,
    output logic [7:0]      red_level,
    output logic [7:0]      green_level,
    output logic [7:0]      blue_level,
    output logic            last_pixel
);

    localparam int IDXW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [IDXW-1:0] LAST_ADDR = IDXW'(PIXEL_COUNT - 1);

    logic [7:0] red_mem   [PIXEL_COUNT];
    logic [7:0] green_mem [PIXEL_COUNT];
    logic [7:0] blue_mem  [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] red_vld_reg, green_vld_reg, blue_vld_reg;

    spfl_pkg::back_state_t state_reg, state_next;
    logic [7:0]      cursor_reg, cursor_next;
    logic [IDXW-1:0] addr_reg, addr_next;
    logic [7:0]      red_rd_reg, green_rd_reg, blue_rd_reg;
    logic            red_ok_reg, green_ok_reg, blue_ok_reg;

    logic            out_valid_reg, out_valid_next;
    logic [5:0]      index_reg;
    logic [7:0]      red_reg, green_reg, blue_reg;
    logic            last_reg;

    logic            in_range;
    logic [IDXW-1:0] wr_addr;
    logic            slot_free;
    logic            load;
    logic            wr_red, wr_green, wr_blue;

    assign in_range  = {1'b0, cursor_reg} < 9'(PIXEL_COUNT);
    assign wr_addr   = cursor_reg[IDXW-1:0];
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = (state_reg == spfl_pkg::ST_IDLE) && not_empty;
    assign load      = (state_reg == spfl_pkg::ST_EMIT) && slot_free;
    assign wr_red    = pop && in_range && (head_op.kind == spfl_pkg::OP_RED);
    assign wr_green  = pop && in_range && (head_op.kind == spfl_pkg::OP_GREEN);
    assign wr_blue   = pop && in_range && (head_op.kind == spfl_pkg::OP_BLUE);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            spfl_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    if (head_op.kind == spfl_pkg::OP_DUMP)
                    begin
                        addr_next  = '0;
                        state_next = spfl_pkg::ST_EMIT;
                    end
                    else if (head_op.kind == spfl_pkg::OP_POSITION)
                    begin
                        cursor_next = head_op.value;
                    end
                end
            end
            spfl_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (addr_reg == LAST_ADDR)
                    begin
                        state_next = spfl_pkg::ST_IDLE;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = spfl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_red)
        begin
            red_mem[wr_addr] <= head_op.value;
        end
        if (wr_green)
        begin
            green_mem[wr_addr] <= head_op.value;
        end
        if (wr_blue)
        begin
            blue_mem[wr_addr] <= head_op.value;
        end
        red_rd_reg   <= red_mem[addr_next];
        green_rd_reg <= green_mem[addr_next];
        blue_rd_reg  <= blue_mem[addr_next];
        red_ok_reg   <= red_vld_reg[addr_next];
        green_ok_reg <= green_vld_reg[addr_next];
        blue_ok_reg  <= blue_vld_reg[addr_next];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= 6'(addr_reg);
            red_reg   <= red_ok_reg ? red_rd_reg : 8'h00;
            green_reg <= green_ok_reg ? green_rd_reg : 8'h00;
            blue_reg  <= blue_ok_reg ? blue_rd_reg : 8'h00;
            last_reg  <= (addr_reg == LAST_ADDR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spfl_pkg::ST_IDLE;
            cursor_reg    <= 8'h00;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            red_vld_reg   <= '0;
            green_vld_reg <= '0;
            blue_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            if (wr_red)
            begin
                red_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_green)
            begin
                green_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_blue)
            begin
                blue_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = index_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;
    assign last_pixel  = last_reg;

endmodule

### hdl/serial_pixel_frame_loader.sv
// ----------------------------------------------------------------------------
// serial_pixel_frame_loader
// Receives command/value byte pairs and maintains a frame of RGB pixels.
//
// Input channel (in_valid/in_ready/rx_byte) takes one byte per beat; bytes
// alternate command then value, each biased by one. Position and colour
// writes produce no output beats; a dump command produces PIXEL_COUNT output
// beats (out_valid/out_ready) in index order, last_pixel set on the final one.
// A decoded pair is stored in the queue on its value beat and is executed
// when the executor pops it. A dump passes through the executor state, the
// registered-read colour memories and the output register before its first
// beat, then streams one pixel per cycle while out_ready stays high. Other
// pairs are executed as they are popped, without leaving ST_IDLE. A two-entry
// queue decouples decoding from execution; while a dump runs the queue fills
// and in_ready drops only on value bytes.
// When the receiver stalls, the output beat holds and the dump pauses.
// Reset clears the cursor, the pairing state and the per-entry valid bits,
// so every colour reads as zero until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module serial_pixel_frame_loader #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  pixel_index,
    output logic [7:0]  red_level,
    output logic [7:0]  green_level,
    output logic [7:0]  blue_level,
    output logic        last_pixel
);

    logic          push;
    spfl_pkg::op_t push_op;
    logic          full;
    logic          pop;
    logic          not_empty;
    spfl_pkg::op_t head_op;

    spfl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .push     (push),
        .push_op  (push_op),
        .full     (full)
    );

    spfl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_op   (head_op)
    );

    spfl_back #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (not_empty),
        .head_op     (head_op),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .last_pixel  (last_pixel)
    );

endmodule
